// File: rtl/tpd_pkg.sv
// ============================================================================
// tpd_pkg
// Shared types and constants for the telemetry packet deframer.
// ============================================================================
package tpd_pkg;

    // parse phases of the deframer
    typedef enum logic [3:0] {
        PH_SYNC0 = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_H0    = 4'd2,
        PH_H1    = 4'd3,
        PH_H2    = 4'd4,
        PH_H3    = 4'd5,
        PH_H4    = 4'd6,
        PH_H5    = 4'd7,
        PH_CSW   = 4'd8,
        PH_MTS   = 4'd9,
        PH_MA    = 4'd10,
        PH_MB    = 4'd11,
        PH_MDATA = 4'd12,
        PH_BODY  = 4'd13,
        PH_SKIP  = 4'd14
    } phase_t;

    // record kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_MESSAGE = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    localparam logic [7:0]  SYNC_BYTE0       = 8'h25;
    localparam logic [7:0]  SYNC_BYTE1       = 8'hEB;
    localparam logic [7:0]  BUS_FORMAT_RESET = 8'h19;
    localparam logic [31:0] HDR_BYTES        = 32'd24;
    localparam logic [15:0] MSG_HDR_IN_LEN   = 16'd4;

    // configuration register indexes
    localparam logic CFG_IDX_BUS_FORMAT = 1'b0;

    // one result word
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] channel_id;
        logic [7:0]  data_type;
        logic [7:0]  data_version;
        logic [7:0]  sequence_res;
        logic [7:0]  packet_flags;
        logic [31:0] length_value;
        logic [31:0] aux_value;
        logic [63:0] time_value;
        logic [31:0] word_value;
        logic [7:0]  byte_value;
        logic        last;
    } record_t;

    // handshake between parser and the stages around it
    typedef struct packed {
        logic take;
        logic emit;
    } parse_ctl_t;

endpackage

// File: rtl/tpd_cfg_regs.sv
// ============================================================================
// tpd_cfg_regs
// APB-style register file holding the bus format data type code.
// ============================================================================
module tpd_cfg_regs
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  bus_format_type
);

    logic [7:0] bus_format_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_BUS_FORMAT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_format_reg <= BUS_FORMAT_RESET;
        end
        else if (wr_en)
        begin
            bus_format_reg <= pwdata[7:0];
        end
    end

    // low two address bits select bytes within the word and are ignored
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_BUS_FORMAT)
        begin
            prdata = {24'd0, bus_format_reg};
        end
    end

    assign bus_format_type = bus_format_reg;

endmodule

// File: rtl/tpd_in_stage.sv
// ============================================================================
// tpd_in_stage
// Input register for stream bytes ahead of the parse logic.
// ============================================================================
module tpd_in_stage
    import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] in_byte,
    input  parse_ctl_t ctl,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign byte_ready = !valid_reg || ctl.take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            byte_reg <= in_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

// File: rtl/tpd_parser.sv
// ============================================================================
// tpd_parser
// Single-pass parse logic and parse state: sync hunt, header, 1553 messages, raw body bytes.
// ============================================================================
module tpd_parser
    import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] bus_format_type,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       slot_free,
    output parse_ctl_t ctl,
    output record_t    rec
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  cnt_reg,    cnt_next;
    logic [63:0] shift_reg,  shift_next;
    logic [31:0] pbl_reg,    pbl_next;
    logic [23:0] ml_reg,     ml_next;
    logic [15:0] mbl_reg,    mbl_next;

    // header store, each field read at a fixed place
    logic [15:0] chan_reg,   chan_next;
    logic [31:0] plen_reg,   plen_next;
    logic [31:0] dlen_reg,   dlen_next;
    logic [31:0] word3_reg,  word3_next;
    logic [31:0] rtc_lo_reg, rtc_lo_next;
    // message store
    logic [63:0] ms0_reg,    ms0_next;
    logic [63:0] ms1_reg,    ms1_next;

    logic [63:0] gathered;
    logic [3:0]  cnt_inc;
    logic        done2, done4, done8;
    logic [31:0] pbl_dec;
    logic        in_body, exhausted;
    logic [15:0] mlen, mbl_new, mbl_dec;
    logic [23:0] ml_dec;
    logic        emit_c;
    logic        take;
    record_t     rec_c;

    assign gathered = shift_reg | ({56'd0, item_byte} << {cnt_reg, 3'b000});
    assign cnt_inc  = {1'b0, cnt_reg} + 4'd1;
    assign done2    = cnt_inc >= 4'd2;
    assign done4    = cnt_inc >= 4'd4;
    assign done8    = cnt_inc >= 4'd8;
    assign pbl_dec  = pbl_reg - {31'd0, (pbl_reg != 32'd0)};
    assign in_body  = (phase_reg >= PH_CSW) && (phase_reg <= PH_SKIP);
    assign exhausted = in_body && (pbl_dec == 32'd0);
    assign mlen     = ms1_reg[47:32];
    assign mbl_new  = (mlen >= MSG_HDR_IN_LEN) ? (mlen - MSG_HDR_IN_LEN) : 16'd0;
    assign mbl_dec  = mbl_reg - {15'd0, (mbl_reg != 16'd0)};
    assign ml_dec   = ml_reg - 24'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        shift_next  = shift_reg;
        pbl_next    = pbl_reg;
        ml_next     = ml_reg;
        mbl_next    = mbl_reg;
        chan_next   = chan_reg;
        plen_next   = plen_reg;
        dlen_next   = dlen_reg;
        word3_next  = word3_reg;
        rtc_lo_next = rtc_lo_reg;
        ms0_next    = ms0_reg;
        ms1_next    = ms1_reg;
        emit_c      = 1'b0;

        rec_c              = '0;
        rec_c.channel_id   = chan_reg;
        rec_c.data_type    = word3_reg[31:24];
        rec_c.data_version = word3_reg[7:0];
        rec_c.sequence_res = word3_reg[15:8];
        rec_c.packet_flags = word3_reg[23:16];

        if (in_body)
        begin
            pbl_next = pbl_dec;
        end

        case (phase_reg)
            PH_SYNC0:
            begin
                shift_next = {56'd0, item_byte};
                phase_next = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                if ((shift_reg[7:0] == SYNC_BYTE0) && (item_byte == SYNC_BYTE1))
                begin
                    phase_next = PH_H0;
                end
                else
                begin
                    phase_next = PH_SYNC0;
                end
                shift_next = '0;
                cnt_next   = '0;
            end
            PH_H0:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done2)
                begin
                    chan_next  = gathered[15:0];
                    shift_next = '0;
                    cnt_next   = '0;
                    phase_next = PH_H1;
                end
            end
            PH_H1, PH_H2, PH_H3, PH_H4:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done4)
                begin
                    shift_next = '0;
                    cnt_next   = '0;
                    case (phase_reg)
                        PH_H1:   begin plen_next   = gathered[31:0]; phase_next = PH_H2; end
                        PH_H2:   begin dlen_next   = gathered[31:0]; phase_next = PH_H3; end
                        PH_H3:   begin word3_next  = gathered[31:0]; phase_next = PH_H4; end
                        default: begin rtc_lo_next = gathered[31:0]; phase_next = PH_H5; end
                    endcase
                end
            end
            PH_H5:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done4)
                begin
                    shift_next         = '0;
                    cnt_next           = '0;
                    emit_c             = 1'b1;
                    rec_c.record_kind  = KIND_HEADER;
                    rec_c.length_value = plen_reg;
                    rec_c.aux_value    = dlen_reg;
                    rec_c.time_value   = {16'd0, gathered[15:0], rtc_lo_reg};
                    rec_c.word_value   = {16'd0, gathered[31:16]};
                    pbl_next = (plen_reg > HDR_BYTES) ? (plen_reg - HDR_BYTES) : 32'd0;
                    if (plen_reg <= HDR_BYTES)
                    begin
                        // empty body: header closes the packet
                        rec_c.last = 1'b1;
                        phase_next = PH_SYNC0;
                    end
                    else if (word3_reg[31:24] == bus_format_type)
                    begin
                        phase_next = PH_CSW;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_CSW:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done4)
                begin
                    shift_next        = '0;
                    cnt_next          = '0;
                    ml_next           = gathered[23:0];
                    emit_c            = 1'b1;
                    rec_c.record_kind = KIND_CHANNEL;
                    rec_c.aux_value   = {8'd0, gathered[23:0]};
                    if (gathered[23:0] == 24'd0)
                    begin
                        rec_c.last = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_MTS;
                    end
                end
            end
            PH_MTS, PH_MA:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done8)
                begin
                    shift_next = '0;
                    cnt_next   = '0;
                    if (phase_reg == PH_MTS)
                    begin
                        ms0_next   = gathered;
                        phase_next = PH_MA;
                    end
                    else
                    begin
                        ms1_next   = gathered;
                        phase_next = PH_MB;
                    end
                end
            end
            PH_MB:
            begin
                shift_next = gathered;
                cnt_next   = cnt_inc[2:0];
                if (done2)
                begin
                    shift_next         = '0;
                    cnt_next           = '0;
                    emit_c             = 1'b1;
                    rec_c.record_kind  = KIND_MESSAGE;
                    rec_c.length_value = {16'd0, mlen};
                    rec_c.aux_value    = ms1_reg[31:0];
                    rec_c.time_value   = ms0_reg;
                    rec_c.word_value   = {gathered[15:0], ms1_reg[63:48]};
                    mbl_next           = mbl_new;
                    ml_next            = ml_dec;
                    if (mbl_new != 16'd0)
                    begin
                        phase_next = PH_MDATA;
                    end
                    else if (ml_dec == 24'd0)
                    begin
                        rec_c.last = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_MTS;
                    end
                end
            end
            PH_MDATA:
            begin
                emit_c            = 1'b1;
                rec_c.record_kind = KIND_PAYLOAD;
                rec_c.byte_value  = item_byte;
                mbl_next          = mbl_dec;
                if (mbl_dec == 16'd0)
                begin
                    if (ml_reg == 24'd0)
                    begin
                        rec_c.last = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_MTS;
                    end
                end
            end
            PH_BODY:
            begin
                emit_c            = 1'b1;
                rec_c.record_kind = KIND_PAYLOAD;
                rec_c.byte_value  = item_byte;
            end
            PH_SKIP:
            begin
                // filler up to the packet length
            end
            default:
            begin
                phase_next = PH_SYNC0;
            end
        endcase

        // packet length ran out: back to sync hunt, drop any partial field
        if (exhausted)
        begin
            rec_c.last = 1'b1;
            phase_next = PH_SYNC0;
            shift_next = '0;
            cnt_next   = '0;
        end
    end

    assign take     = item_valid && (!emit_c || slot_free);
    assign ctl.take = take;
    assign ctl.emit = take && emit_c;
    assign rec      = rec_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC0;
            cnt_reg   <= '0;
            shift_reg <= '0;
            pbl_reg   <= '0;
            ml_reg    <= '0;
            mbl_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            pbl_reg   <= pbl_next;
            ml_reg    <= ml_next;
            mbl_reg   <= mbl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chan_reg   <= chan_next;
            plen_reg   <= plen_next;
            dlen_reg   <= dlen_next;
            word3_reg  <= word3_next;
            rtc_lo_reg <= rtc_lo_next;
            ms0_reg    <= ms0_next;
            ms1_reg    <= ms1_next;
        end
    end

endmodule

// File: rtl/tpd_out_stage.sv
// ============================================================================
// tpd_out_stage
// Result register holding one record word until the sink takes it.
// ============================================================================
module tpd_out_stage
    import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  parse_ctl_t ctl,
    input  record_t    rec_in,
    output logic       slot_free,
    output logic       record_valid,
    input  logic       record_ready,
    output record_t    rec_out
);

    logic    valid_reg;
    record_t rec_reg;

    assign slot_free = !valid_reg || record_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (record_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rec_reg <= rec_in;
        end
    end

    assign record_valid = valid_reg;
    assign rec_out      = rec_reg;

endmodule

// File: rtl/telemetry_packet_deframer_core.sv
// ============================================================================
// telemetry_packet_deframer_core
// Chapter 10 style packet deframer with MIL-1553 format 1 message decoding.
// ============================================================================
// The core takes one stream byte per cycle and gives at most one record word
// per byte. Sustained rate is one byte every cycle while the record sink keeps
// record_ready high; a byte that yields a record is held in the input register
// while the result register is full and not being taken. From byte
// acceptance to record_valid, the byte sits in the input register while the parse
// step runs, and the record lands in the result register, with the whole
// parse step (field shift, 32-bit packet length decrement, message counters)
// done in a single pass between the two registers.
// Sync is hunted in byte pairs (0x25 0xEB); mismatching pairs are dropped.
// A 24-byte little-endian header gives one header record. If its data type
// matches bus_format_type, the body is decoded as channel word, then per
// message an 18-byte block record followed by payload byte records; other
// types give body bytes as payload records. The packet length bounds the
// body, trailing filler is skipped, and last marks the closing record.
// No clearing pass after reset; the core is ready right after reset release.
// bus_format_type is register 0 at byte address 0 (reset 0x19).
module telemetry_packet_deframer_core
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // apb-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // byte stream
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  in_byte,

    // record words
    output logic        record_valid,
    input  logic        record_ready,
    output logic [1:0]  record_kind,
    output logic [15:0] channel_id,
    output logic [7:0]  data_type,
    output logic [7:0]  data_version,
    output logic [7:0]  sequence_res,
    output logic [7:0]  packet_flags,
    output logic [31:0] length_value,
    output logic [31:0] aux_value,
    output logic [63:0] time_value,
    output logic [31:0] word_value,
    output logic [7:0]  byte_value,
    output logic        last
);

    logic [7:0] bus_format_type;
    logic       item_valid;
    logic [7:0] item_byte;
    logic       slot_free;
    parse_ctl_t ctl;
    record_t    rec_parse;
    record_t    rec_out;

    // configuration register
    tpd_cfg_regs u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .bus_format_type (bus_format_type)
    );

    // input register; frees up as soon as the parser consumes the byte
    tpd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .in_byte    (in_byte),
        .ctl        (ctl),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    // parse step; bytes that yield no record never wait on the sink
    tpd_parser u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .bus_format_type (bus_format_type),
        .item_valid      (item_valid),
        .item_byte       (item_byte),
        .slot_free       (slot_free),
        .ctl             (ctl),
        .rec             (rec_parse)
    );

    // result register
    tpd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .rec_in       (rec_parse),
        .slot_free    (slot_free),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .rec_out      (rec_out)
    );

    // record word fields
    assign record_kind  = rec_out.record_kind;
    assign channel_id   = rec_out.channel_id;
    assign data_type    = rec_out.data_type;
    assign data_version = rec_out.data_version;
    assign sequence_res = rec_out.sequence_res;
    assign packet_flags = rec_out.packet_flags;
    assign length_value = rec_out.length_value;
    assign aux_value    = rec_out.aux_value;
    assign time_value   = rec_out.time_value;
    assign word_value   = rec_out.word_value;
    assign byte_value   = rec_out.byte_value;
    assign last         = rec_out.last;

endmodule

// File: test/telemetry_packet_deframer_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// telemetry_packet_deframer_core_tb
// Drives random chapter 10 style byte streams into the deframer, mirrors the
// parse in a local predictor and checks every record word in order, across
// several bus format settings and sender and receiver idling patterns.
// ============================================================================
module telemetry_packet_deframer_core_tb;
    import tpd_pkg::*;

    localparam logic [2:0] CFG_ADDR_BUS_FORMAT = 3'd4 * CFG_IDX_BUS_FORMAT;
    localparam logic [2:0] CFG_ADDR_UNUSED     = 3'd4;
    localparam int         DRAIN_CYCLES        = 8;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        byte_valid   = 1'b0;
    logic        byte_ready;
    logic [7:0]  in_byte      = '0;
    logic        record_valid;
    logic        record_ready = 1'b0;
    logic [1:0]  record_kind;
    logic [15:0] channel_id;
    logic [7:0]  data_type;
    logic [7:0]  data_version;
    logic [7:0]  sequence_res;
    logic [7:0]  packet_flags;
    logic [31:0] length_value;
    logic [31:0] aux_value;
    logic [63:0] time_value;
    logic [31:0] word_value;
    logic [7:0]  byte_value;
    logic        last;

    telemetry_packet_deframer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .in_byte      (in_byte),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record_kind  (record_kind),
        .channel_id   (channel_id),
        .data_type    (data_type),
        .data_version (data_version),
        .sequence_res (sequence_res),
        .packet_flags (packet_flags),
        .length_value (length_value),
        .aux_value    (aux_value),
        .time_value   (time_value),
        .word_value   (word_value),
        .byte_value   (byte_value),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [7:0]  stream_bytes[$];
    record_t     predicted_records[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bad_words      = 0;
    int unsigned words_seen     = 0;
    logic        owe_byte       = 1'b0;

    // predictor state, mirrors the parser
    logic [7:0]  bus_fmt_cfg    = BUS_FORMAT_RESET;
    phase_t      pr_phase       = PH_SYNC0;
    logic [3:0]  pr_count       = '0;
    logic [63:0] pr_shift       = '0;
    logic [31:0] pr_hdr[6]      = '{default: '0};
    logic [31:0] pr_body_left   = '0;
    logic [23:0] pr_msgs_left   = '0;
    logic [15:0] pr_data_left   = '0;
    logic [63:0] pr_msg[2]      = '{default: '0};

    // little-endian field gather, true once need bytes are in
    function automatic logic take_byte(input logic [7:0] b, input logic [3:0] need);
        pr_shift = pr_shift | ({56'd0, b} << (8 * pr_count[2:0]));
        pr_count = pr_count + 4'd1;
        if (pr_count >= need)
        begin
            pr_count = 4'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic record_t base_record(input logic [1:0] kind);
        record_t rec;
        rec              = '0;
        rec.record_kind  = kind;
        rec.channel_id   = pr_hdr[0][31:16];
        rec.data_type    = pr_hdr[3][31:24];
        rec.data_version = pr_hdr[3][7:0];
        rec.sequence_res = pr_hdr[3][15:8];
        rec.packet_flags = pr_hdr[3][23:16];
        return rec;
    endfunction

    // next message or skip to the packet length; true when messages are done
    function automatic logic close_message();
        if (pr_msgs_left == 24'd0)
        begin
            pr_phase = PH_SKIP;
            return 1'b1;
        end
        pr_phase = PH_MTS;
        return 1'b0;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        record_t     rec;
        logic        emit;
        logic        is_last;
        logic        drained;
        phase_t      ph;
        logic [31:0] plen;
        logic [63:0] m;
        logic [15:0] mlen;
        emit    = 1'b0;
        is_last = 1'b0;
        drained = 1'b0;
        rec     = '0;
        ph      = pr_phase;
        // body bytes count down against the packet length
        if (ph >= PH_CSW && ph <= PH_SKIP)
        begin
            if (pr_body_left != 32'd0)
                pr_body_left = pr_body_left - 32'd1;
            drained = (pr_body_left == 32'd0);
        end
        case (ph)
            PH_SYNC0:
            begin
                pr_shift = {56'd0, b};
                pr_phase = PH_SYNC1;
            end
            PH_SYNC1:
            begin
                if (pr_shift[7:0] == SYNC_BYTE0 && b == SYNC_BYTE1)
                    pr_phase = PH_H0;
                else
                    pr_phase = PH_SYNC0;
                pr_shift = '0;
                pr_count = '0;
            end
            PH_H0:
            begin
                if (take_byte(b, 4'd2))
                begin
                    pr_hdr[0] = {pr_shift[15:0], SYNC_BYTE1, SYNC_BYTE0};
                    pr_shift  = '0;
                    pr_phase  = PH_H1;
                end
            end
            PH_H1, PH_H2, PH_H3, PH_H4, PH_H5:
            begin
                if (take_byte(b, 4'd4))
                begin
                    pr_hdr[ph - PH_H0] = pr_shift[31:0];
                    pr_shift = '0;
                    if (ph != PH_H5)
                        pr_phase = phase_t'(ph + 1);
                    else
                    begin
                        plen             = pr_hdr[1];
                        rec              = base_record(KIND_HEADER);
                        rec.length_value = plen;
                        rec.aux_value    = pr_hdr[2];
                        rec.time_value   = {16'd0, pr_hdr[5][15:0], pr_hdr[4]};
                        rec.word_value   = {16'd0, pr_hdr[5][31:16]};
                        emit             = 1'b1;
                        pr_body_left     = (plen > HDR_BYTES) ? plen - HDR_BYTES : 32'd0;
                        if (pr_body_left == 32'd0)
                        begin
                            is_last  = 1'b1;
                            pr_phase = PH_SYNC0;
                        end
                        else if (pr_hdr[3][31:24] == bus_fmt_cfg)
                            pr_phase = PH_CSW;
                        else
                            pr_phase = PH_BODY;
                    end
                end
            end
            PH_CSW:
            begin
                if (take_byte(b, 4'd4))
                begin
                    pr_msgs_left  = pr_shift[23:0];
                    pr_shift      = '0;
                    rec           = base_record(KIND_CHANNEL);
                    rec.aux_value = {8'd0, pr_msgs_left};
                    emit          = 1'b1;
                    if (pr_msgs_left == 24'd0)
                    begin
                        is_last  = 1'b1;
                        pr_phase = PH_SKIP;
                    end
                    else
                        pr_phase = PH_MTS;
                end
            end
            PH_MTS:
            begin
                if (take_byte(b, 4'd8))
                begin
                    pr_msg[0] = pr_shift;
                    pr_shift  = '0;
                    pr_phase  = PH_MA;
                end
            end
            PH_MA:
            begin
                if (take_byte(b, 4'd8))
                begin
                    pr_msg[1] = pr_shift;
                    pr_shift  = '0;
                    pr_phase  = PH_MB;
                end
            end
            PH_MB:
            begin
                if (take_byte(b, 4'd2))
                begin
                    m                = pr_msg[1];
                    mlen             = m[47:32];
                    rec              = base_record(KIND_MESSAGE);
                    rec.length_value = {16'd0, mlen};
                    rec.aux_value    = m[31:0];
                    rec.time_value   = pr_msg[0];
                    rec.word_value   = {pr_shift[15:0], m[63:48]};
                    emit             = 1'b1;
                    pr_shift         = '0;
                    pr_data_left     = (mlen >= MSG_HDR_IN_LEN) ? mlen - MSG_HDR_IN_LEN : 16'd0;
                    pr_msgs_left     = pr_msgs_left - 24'd1;
                    if (pr_data_left != 16'd0)
                        pr_phase = PH_MDATA;
                    else
                        is_last = close_message();
                end
            end
            PH_MDATA:
            begin
                rec            = base_record(KIND_PAYLOAD);
                rec.byte_value = b;
                emit           = 1'b1;
                if (pr_data_left != 16'd0)
                    pr_data_left = pr_data_left - 16'd1;
                if (pr_data_left == 16'd0)
                    is_last = close_message();
            end
            PH_BODY:
            begin
                rec            = base_record(KIND_PAYLOAD);
                rec.byte_value = b;
                emit           = 1'b1;
            end
            PH_SKIP:
            begin
                // filler up to the packet length
            end
            default:
                pr_phase = PH_SYNC0;
        endcase
        // packet length ran out: back to sync hunt, partial field dropped
        if (drained)
        begin
            is_last  = 1'b1;
            pr_phase = PH_SYNC0;
            pr_shift = '0;
            pr_count = '0;
        end
        if (emit)
        begin
            rec.last = is_last;
            predicted_records.push_back(rec);
        end
    endtask

    function automatic string fmt_record(input record_t r);
        return $sformatf({"kind=%0d ch=%h type=%h ver=%h seq=%h flags=%h len=%h aux=%h",
                          " time=%h word=%h byte=%h last=%0d"},
                         r.record_kind, r.channel_id, r.data_type, r.data_version,
                         r.sequence_res, r.packet_flags, r.length_value, r.aux_value,
                         r.time_value, r.word_value, r.byte_value, r.last);
    endfunction

    // byte driver, valid held until the byte is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            in_byte    <= '0;
        end
        else
        begin
            if (byte_valid && byte_ready)
                deframe_byte(in_byte);
            if (!byte_valid || byte_ready)
            begin
                if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    in_byte    <= stream_bytes.pop_front();
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // record monitor and sink stalls
    record_t got_word;
    record_t want_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            record_ready <= 1'b0;
        else
        begin
            if (record_valid && record_ready)
            begin
                got_word = {record_kind, channel_id, data_type, data_version, sequence_res,
                            packet_flags, length_value, aux_value, time_value, word_value,
                            byte_value, last};
                if (predicted_records.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display("word %0d not predicted: %s", words_seen, fmt_record(got_word));
                end
                else
                begin
                    want_word = predicted_records.pop_front();
                    if (got_word !== want_word)
                    begin
                        bad_words++;
                        if (bad_words <= 10)
                        begin
                            $display("word %0d mismatch", words_seen);
                            $display("  expected %s", fmt_record(want_word));
                            $display("  actual   %s", fmt_record(got_word));
                        end
                    end
                end
                words_seen++;
            end
            record_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic push_le(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            stream_bytes.push_back(v[8*i +: 8]);
    endtask

    // one packet with random content, mostly well formed
    task automatic add_packet();
        logic [7:0]  body[$];
        logic [7:0]  dtype;
        logic [7:0]  junk;
        logic [31:0] plen;
        logic [23:0] msg_count;
        logic [15:0] mlen;
        int          n_msgs;
        int          n_data;
        int          cut;
        int          filler;
        int          roll;
        body.delete();
        filler = 0;
        if (owe_byte)
        begin
            stream_bytes.push_back(8'($urandom));
            owe_byte = 1'b0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
            repeat (2 * $urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
        else if (roll < 11)
        begin
            // broken pair, sync byte then not its partner
            junk = 8'($urandom);
            stream_bytes.push_back(SYNC_BYTE0);
            stream_bytes.push_back(junk == SYNC_BYTE1 ? 8'h00 : junk);
        end
        else if (roll < 14)
        begin
            junk = 8'($urandom);
            stream_bytes.push_back(junk == SYNC_BYTE0 ? 8'hFF : junk);
            stream_bytes.push_back(SYNC_BYTE1);
        end
        else if (roll < 17)
        begin
            // knock pair alignment off for this packet only
            stream_bytes.push_back(8'($urandom));
            owe_byte = 1'b1;
        end

        dtype = ($urandom_range(0, 99) < 60) ? bus_fmt_cfg : 8'($urandom);
        if (dtype == bus_fmt_cfg)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                msg_count = 24'd0;
            else if (roll < 90)
                msg_count = 24'($urandom_range(1, 3));
            else
                msg_count = 24'($urandom);
            n_msgs = (msg_count > 24'd3) ? 3 : int'(msg_count);
            for (int i = 0; i < 4; i++)
                body.push_back(i < 3 ? msg_count[8*i +: 8] : 8'($urandom));
            for (int k = 0; k < n_msgs; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    mlen = 16'(4 + $urandom_range(0, 10));
                else if (roll < 85)
                    mlen = 16'($urandom_range(0, 3));
                else
                    mlen = 16'($urandom);
                for (int i = 0; i < 8; i++)
                    body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(mlen[7:0]);
                body.push_back(mlen[15:8]);
                repeat (4) body.push_back(8'($urandom));
                n_data = (mlen >= 16'd4) ? int'(mlen) - 4 : 0;
                if (n_data > 24)
                    n_data = 24;
                repeat (n_data) body.push_back(8'($urandom));
            end
        end
        else
            repeat ($urandom_range(0, 16)) body.push_back(8'($urandom));

        roll = $urandom_range(0, 99);
        if (roll < 65)
            plen = HDR_BYTES + 32'(body.size());
        else if (roll < 77)
        begin
            filler = $urandom_range(1, 6);
            plen   = HDR_BYTES + 32'(body.size() + filler);
        end
        else if (roll < 90)
        begin
            // length runs out inside the body
            cut = (body.size() > 1) ? $urandom_range(0, body.size() - 1) : 0;
            while (body.size() > cut)
                void'(body.pop_back());
            plen = HDR_BYTES + 32'(cut);
        end
        else
        begin
            body.delete();
            plen = 32'($urandom_range(0, 24));
        end

        stream_bytes.push_back(SYNC_BYTE0);
        stream_bytes.push_back(SYNC_BYTE1);
        push_le(64'($urandom), 2);
        push_le(64'(plen), 4);
        push_le(64'($urandom), 4);
        push_le(64'($urandom), 3);
        stream_bytes.push_back(dtype);
        push_le({$urandom, $urandom}, 6);
        push_le(64'($urandom), 2);
        foreach (body[i])
            stream_bytes.push_back(body[i]);
        repeat (filler) stream_bytes.push_back(8'($urandom));
    endtask

    task automatic add_packets(input int nbytes);
        int start_size;
        start_size = stream_bytes.size();
        while (stream_bytes.size() - start_size < nbytes)
            add_packet();
    endtask

    // everything sent and every predicted word back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        while (stream_bytes.size() != 0 || byte_valid || predicted_records.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CFG_ADDR_BUS_FORMAT)
            bus_fmt_cfg = data[7:0];
        @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: both kinds of broken sync pair, then an extreme header-only packet
        stream_bytes.push_back(SYNC_BYTE0);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(SYNC_BYTE1);
        stream_bytes.push_back(SYNC_BYTE0);
        stream_bytes.push_back(SYNC_BYTE1);
        push_le(64'hFFFF, 2);
        push_le(64'(HDR_BYTES), 4);
        push_le(64'hFFFF_FFFF, 4);
        push_le(64'h00FF00, 3);
        stream_bytes.push_back(8'hFF);
        push_le(64'hFFFF_FFFF_FFFF, 6);
        push_le(64'h0000, 2);
        add_packets(330);
        drain();

        // bus format at zero, sender mostly idle
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        write_cfg(CFG_ADDR_BUS_FORMAT, 32'hABCD_EF00);
        add_packets(370);
        drain();

        // bus format at its top value, sink mostly stalled
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        write_cfg(CFG_ADDR_BUS_FORMAT, 32'h0000_00FF);
        add_packets(370);
        drain();

        // random bus format with junk upper bits, both sides idling
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        write_cfg(CFG_ADDR_BUS_FORMAT, $urandom);
        add_packets(370);
        drain();

        // unmapped address must be ignored, then back to the reset format
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_cfg(CFG_ADDR_UNUSED, 32'h0000_0055);
        add_packets(100);
        drain();
        write_cfg(CFG_ADDR_BUS_FORMAT, {24'h00_0000, BUS_FORMAT_RESET});
        add_packets(270);
        drain();

        if (bad_words == 0 && predicted_records.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/tpd_pkg.sv
rtl/tpd_cfg_regs.sv
rtl/tpd_in_stage.sv
rtl/tpd_parser.sv
rtl/tpd_out_stage.sv
rtl/telemetry_packet_deframer_core.sv
test/telemetry_packet_deframer_core_tb.sv
